>>> rtl/lss_pkg.sv
// leg swing/stance selector: shared types, register indexes, state codes and helpers
// used by lss_cfg, lss_step and leg_swing_stance_selector; no dependencies
package lss_pkg;

	// default build values
	localparam int ANGLE_FRAC_BITS_DEF = 13;
	localparam int DEADBAND_COARSE_DEF = 82;
	localparam int DEADBAND_FINE_DEF   = 16;

	// angle width and the extended width for offset sums (offsets stay below 2^22)
	localparam int ANG_W     = 16;
	localparam int ANG_EXT_W = 24;
	localparam int ERR_W     = ANG_W + 1;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PEP_COXA  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEP_FEMUR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEP_TIBIA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MID_FEMUR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MID_TIBIA = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AEP_COXA  = 3'd5;

	// register reset values
	localparam logic signed [ANG_W-1:0] PEP_COXA_RST  = 16'sd3277;
	localparam logic signed [ANG_W-1:0] PEP_FEMUR_RST = 16'sd7373;
	localparam logic signed [ANG_W-1:0] PEP_TIBIA_RST = -16'sd4506;
	localparam logic signed [ANG_W-1:0] MID_FEMUR_RST = 16'sd8192;
	localparam logic signed [ANG_W-1:0] MID_TIBIA_RST = -16'sd8192;
	localparam logic signed [ANG_W-1:0] AEP_COXA_RST  = -16'sd7373;

	// swing and stance machine codes
	localparam logic [1:0] SW_IDLE   = 2'd0;
	localparam logic [1:0] SW_LIFT   = 2'd1;
	localparam logic [1:0] SW_TO_AEP = 2'd2;
	localparam logic [1:0] SW_LOWER  = 2'd3;
	localparam logic       ST_IDLE   = 1'b0;
	localparam logic       ST_TO_PEP = 1'b1;

	// write mask bits
	localparam logic [2:0] MASK_ALL   = 3'b111;
	localparam logic [2:0] MASK_FEMUR = 3'b010;
	localparam logic [2:0] MASK_FT    = 3'b110;

	typedef struct packed {
		logic signed [ANG_W-1:0] pep_coxa;
		logic signed [ANG_W-1:0] pep_femur;
		logic signed [ANG_W-1:0] pep_tibia;
		logic signed [ANG_W-1:0] mid_femur;
		logic signed [ANG_W-1:0] mid_tibia;
		logic signed [ANG_W-1:0] aep_coxa;
	} lss_cfg_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] coxa;
		logic signed [ANG_W-1:0] femur;
		logic signed [ANG_W-1:0] tibia;
		logic [5:0]              contact;
		logic                    inhibit;
		logic                    excite_two;
		logic                    excite_three;
		logic                    clear_touch;
	} lss_item_t;

	typedef struct packed {
		logic       return_to_swing;
		logic       power_stroke;
		logic       start_swing;
		logic       start_stance;
		logic       phase;
		logic       pre_touch;
		logic       touch;
		logic       near_pep;
		logic [1:0] swing_fsm;
		logic       stance_fsm;
	} lss_state_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] via_coxa;
		logic signed [ANG_W-1:0] via_femur;
		logic signed [ANG_W-1:0] via_tibia;
		logic [2:0]              mask;
		logic                    position_mode;
		logic                    swing_phase;
		logic                    foot_down;
		logic                    near_pep_toggle;
		logic [1:0]              swing_state;
		logic                    stance_state;
	} lss_result_t;

	// |target - angle| < band
	function automatic logic near_to(input logic signed [ANG_W-1:0] tgt,
		input logic signed [ANG_W-1:0] ang, input logic [ERR_W-1:0] band);
		logic signed [ERR_W-1:0] e;
		logic [ERR_W-1:0]        m;
		e = {tgt[ANG_W-1], tgt} - {ang[ANG_W-1], ang};
		m = e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
		return m < band;
	endfunction

	function automatic logic signed [ANG_EXT_W-1:0] ext(input logic signed [ANG_W-1:0] a);
		return {{(ANG_EXT_W-ANG_W){a[ANG_W-1]}}, a};
	endfunction

	// clamp to the 16-bit signed range
	function automatic logic signed [ANG_W-1:0] sat16(input logic signed [ANG_EXT_W-1:0] v);
		logic in_range;
		in_range = (v[ANG_EXT_W-1:ANG_W-1] == '0) || (v[ANG_EXT_W-1:ANG_W-1] == '1);
		if (in_range) begin
			return v[ANG_W-1:0];
		end
		return v[ANG_EXT_W-1] ? 16'sh8000 : 16'sh7fff;
	endfunction

endpackage

>>> rtl/leg_swing_stance_selector.sv
// leg swing/stance selector top level: input register, step logic, result register
// an accepted item is held in the input register and its result then in the result register,
// which drives the outputs; throughput: one item per cycle while the output is not stalled;
// the leg state is updated as an item leaves the input register
// stall on the input side rises only when both registers are full and the output is stalled
// reset clears the leg state to idle and loads the default extreme positions
module leg_swing_stance_selector
	import lss_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int DEADBAND_COARSE = DEADBAND_COARSE_DEF,
	parameter int DEADBAND_FINE   = DEADBAND_FINE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic signed [ANG_W-1:0] cfg_data,

	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [ANG_W-1:0] coxa_angle,
	input  logic signed [ANG_W-1:0] femur_angle,
	input  logic signed [ANG_W-1:0] tibia_angle,
	input  logic [5:0]              contact_bits,
	input  logic                    rule_inhibit,
	input  logic                    rule_excite_two,
	input  logic                    rule_excite_three,
	input  logic                    clear_touch_down,

	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [ANG_W-1:0] via_coxa,
	output logic signed [ANG_W-1:0] via_femur,
	output logic signed [ANG_W-1:0] via_tibia,
	output logic [2:0]              via_write_mask,
	output logic                    position_mode,
	output logic                    swing_phase,
	output logic                    foot_down,
	output logic                    near_pep_toggle,
	output logic [1:0]              swing_state,
	output logic                    stance_state
);

	lss_cfg_t    cfg;
	lss_item_t   item_s1;
	logic        valid_s1;
	lss_state_t  state_q, state_nxt;
	lss_result_t res_nxt, res_q;
	logic        out_valid_q;
	logic        in_xfer, advance;

	assign cfg_ready = 1'b1;

	lss_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// item moves into the result register when that register is empty or drains
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.coxa         <= coxa_angle;
			item_s1.femur        <= femur_angle;
			item_s1.tibia        <= tibia_angle;
			item_s1.contact      <= contact_bits;
			item_s1.inhibit      <= rule_inhibit;
			item_s1.excite_two   <= rule_excite_two;
			item_s1.excite_three <= rule_excite_three;
			item_s1.clear_touch  <= clear_touch_down;
		end
	end

	lss_step #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.DEADBAND_COARSE (DEADBAND_COARSE),
		.DEADBAND_FINE   (DEADBAND_FINE)
	) u_step (
		.cfg  (cfg),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			out_valid_q <= advance || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign via_coxa        = res_q.via_coxa;
	assign via_femur       = res_q.via_femur;
	assign via_tibia       = res_q.via_tibia;
	assign via_write_mask  = res_q.mask;
	assign position_mode   = res_q.position_mode;
	assign swing_phase     = res_q.swing_phase;
	assign foot_down       = res_q.foot_down;
	assign near_pep_toggle = res_q.near_pep_toggle;
	assign swing_state     = res_q.swing_state;
	assign stance_state    = res_q.stance_state;

	// input side only stalls with an item waiting in the input register
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stall without a held item");

	// an item leaving the input register shows up as a result next cycle
	a_advance_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced item lost before the result register");

	// the coxa target is only written by the swing or stance machine
	a_coxa_posmode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && via_write_mask[0]) |-> position_mode)
		else $error("coxa target written outside position control");

	// leg state only changes when an item completes
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("leg state changed without an item");

endmodule

>>> rtl/lss_cfg.sv
// leg swing/stance selector: configuration register file
// depends on lss_pkg for register indexes and reset values
module lss_cfg
	import lss_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [CFG_IDX_W-1:0]    wr_index,
	input  logic signed [ANG_W-1:0] wr_data,
	output lss_cfg_t                cfg
);

	lss_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pep_coxa  <= PEP_COXA_RST;
			cfg_q.pep_femur <= PEP_FEMUR_RST;
			cfg_q.pep_tibia <= PEP_TIBIA_RST;
			cfg_q.mid_femur <= MID_FEMUR_RST;
			cfg_q.mid_tibia <= MID_TIBIA_RST;
			cfg_q.aep_coxa  <= AEP_COXA_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_PEP_COXA:  cfg_q.pep_coxa  <= wr_data;
				REG_PEP_FEMUR: cfg_q.pep_femur <= wr_data;
				REG_PEP_TIBIA: cfg_q.pep_tibia <= wr_data;
				REG_MID_FEMUR: cfg_q.mid_femur <= wr_data;
				REG_MID_TIBIA: cfg_q.mid_tibia <= wr_data;
				REG_AEP_COXA:  cfg_q.aep_coxa  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/lss_step.sv
// leg swing/stance selector: one control tick of selector, swing and stance logic
// combinational next state and result; depends on lss_pkg
module lss_step
	import lss_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int DEADBAND_COARSE = DEADBAND_COARSE_DEF,
	parameter int DEADBAND_FINE   = DEADBAND_FINE_DEF
) (
	input  lss_cfg_t    cfg,
	input  lss_item_t   item,
	input  lss_state_t  cur,
	output lss_state_t  nxt,
	output lss_result_t res
);

	localparam int QONE    = 1 << ANGLE_FRAC_BITS;
	localparam int OFS_020 = (QONE * 2 + 5) / 10;
	localparam int OFS_006 = (QONE * 6 + 50) / 100;
	localparam int OFS_003 = (QONE * 3 + 50) / 100;
	localparam int OFS_030 = (QONE * 3 + 5) / 10;

	localparam logic signed [ANG_EXT_W-1:0] OFS_020_X = ANG_EXT_W'(OFS_020);
	localparam logic signed [ANG_EXT_W-1:0] OFS_006_X = ANG_EXT_W'(OFS_006);
	localparam logic signed [ANG_EXT_W-1:0] OFS_003_X = ANG_EXT_W'(OFS_003);
	localparam logic signed [ANG_EXT_W-1:0] OFS_030_X = ANG_EXT_W'(OFS_030);

	localparam logic [ERR_W-1:0] BAND_C = ERR_W'(DEADBAND_COARSE);
	localparam logic [ERR_W-1:0] BAND_F = ERR_W'(DEADBAND_FINE);

	logic       gc, trig, near_pep_c;
	logic [1:0] up_cnt;
	logic       at_pep_c, at_pep_f;
	lss_state_t s;
	logic signed [ANG_W-1:0] via0, via1, via2;
	logic [2:0] mask;
	logic       posmode;

	assign gc         = |item.contact;
	assign near_pep_c = near_to(cfg.pep_coxa, item.coxa, BAND_C);
	// rule sum near + r2 + r3 - r1 clamped, so trigger when the excitations beat the inhibit
	assign up_cnt     = 2'(near_pep_c) + 2'(item.excite_two) + 2'(item.excite_three);
	assign trig       = up_cnt > 2'(item.inhibit);
	assign at_pep_c   = near_to(cfg.pep_coxa, item.coxa, BAND_C) &&
		near_to(cfg.pep_femur, item.femur, BAND_C) &&
		near_to(cfg.pep_tibia, item.tibia, BAND_C);
	assign at_pep_f   = near_to(cfg.pep_coxa, item.coxa, BAND_F) &&
		near_to(cfg.pep_femur, item.femur, BAND_F) &&
		near_to(cfg.pep_tibia, item.tibia, BAND_F);

	always_comb begin
		s       = cur;
		via0    = '0;
		via1    = '0;
		via2    = '0;
		mask    = '0;
		posmode = 1'b0;

		if (item.clear_touch) begin
			s.touch = 1'b0;
		end

		if (trig && gc) begin
			via1 = sat16(ext(item.femur) + OFS_020_X);
			via2 = sat16(ext(item.tibia) - OFS_020_X);
			mask = mask | MASK_FT;
		end

		s.return_to_swing = (2'(cur.return_to_swing) + 2'(trig)) > 2'(gc);
		s.power_stroke    = (2'(cur.power_stroke) + 2'(gc)) > 2'(trig);

		if (s.power_stroke && s.pre_touch) begin
			s.pre_touch   = 1'b0;
			s.start_swing = 1'b0;
			s.touch       = 1'b1;
		end

		if (s.return_to_swing) begin
			s.start_swing  = 1'b1;
			s.start_stance = 1'b0;
			s.phase        = 1'b1;
			posmode        = 1'b1;
			case (s.swing_fsm)
				SW_LIFT: begin
					if (!near_to(cfg.mid_femur, item.femur, BAND_C) &&
						!near_to(cfg.mid_tibia, item.tibia, BAND_C)) begin
						via0 = cfg.pep_coxa;
						via1 = cfg.mid_femur;
						via2 = cfg.mid_tibia;
						mask = mask | MASK_ALL;
					end else begin
						s.swing_fsm = SW_TO_AEP;
					end
				end
				SW_TO_AEP: begin
					if (!near_to(cfg.aep_coxa, item.coxa, BAND_C)) begin
						via0 = cfg.aep_coxa;
						via1 = cfg.mid_femur;
						via2 = cfg.mid_tibia;
						mask = mask | MASK_ALL;
					end else begin
						s.swing_fsm = SW_LOWER;
					end
				end
				SW_LOWER: begin
					if (!gc) begin
						via1        = sat16(ext(item.femur) - OFS_030_X);
						mask        = mask | MASK_FEMUR;
						s.pre_touch = 1'b1;
					end else begin
						s.touch       = 1'b1;
						s.start_swing = 1'b0;
						s.swing_fsm   = SW_IDLE;
					end
				end
				default: begin
					if (s.start_swing) begin
						s.swing_fsm = SW_LIFT;
					end
				end
			endcase
		end else if (trig && gc) begin
			via1 = sat16(ext(item.femur) + OFS_006_X);
			via2 = sat16(ext(item.tibia) - OFS_003_X);
			mask = mask | MASK_FT;
		end else if (s.power_stroke) begin
			s.start_swing  = 1'b0;
			s.start_stance = 1'b1;
			s.phase        = 1'b0;
			posmode        = 1'b1;
			if (s.stance_fsm == ST_TO_PEP) begin
				if (!at_pep_c) begin
					via0 = cfg.pep_coxa;
					via1 = cfg.pep_femur;
					via2 = cfg.pep_tibia;
					mask = mask | MASK_ALL;
				end else begin
					s.start_stance = 1'b0;
					s.stance_fsm   = ST_IDLE;
				end
			end else if (s.start_stance) begin
				s.stance_fsm = ST_TO_PEP;
			end
			// toggles while held inside the fine band
			s.near_pep = at_pep_f && !cur.near_pep;
		end
	end

	assign nxt = s;

	always_comb begin
		res.via_coxa        = via0;
		res.via_femur       = via1;
		res.via_tibia       = via2;
		res.mask            = mask;
		res.position_mode   = posmode;
		res.swing_phase     = s.phase;
		res.foot_down       = s.touch;
		res.near_pep_toggle = s.near_pep;
		res.swing_state     = s.swing_fsm;
		res.stance_state    = s.stance_fsm;
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// testbench for leg_swing_stance_selector: directed leg cycle, then randomized walking cycles
// under several register settings; every result is checked against a behavioral leg model
// depends on lss_pkg and the selector rtl only
module tb;
	import lss_pkg::*;

	localparam int COARSE      = DEADBAND_COARSE_DEF;
	localparam int FINE        = DEADBAND_FINE_DEF;
	localparam int QONE        = 1 << ANGLE_FRAC_BITS_DEF;
	localparam int LIFT_OFS    = (QONE * 2 + 5) / 10;
	localparam int NUDGE_FEMUR = (QONE * 6 + 50) / 100;
	localparam int NUDGE_TIBIA = (QONE * 3 + 50) / 100;
	localparam int LOWER_OFS   = (QONE * 3 + 5) / 10;
	localparam int QUIET_LIMIT = 2000;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic signed [ANG_W-1:0] cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [ANG_W-1:0] coxa_angle = '0;
	logic signed [ANG_W-1:0] femur_angle = '0;
	logic signed [ANG_W-1:0] tibia_angle = '0;
	logic [5:0]              contact_bits = '0;
	logic                    rule_inhibit = 1'b0;
	logic                    rule_excite_two = 1'b0;
	logic                    rule_excite_three = 1'b0;
	logic                    clear_touch_down = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [ANG_W-1:0] via_coxa;
	logic signed [ANG_W-1:0] via_femur;
	logic signed [ANG_W-1:0] via_tibia;
	logic [2:0]              via_write_mask;
	logic                    position_mode;
	logic                    swing_phase;
	logic                    foot_down;
	logic                    near_pep_toggle;
	logic [1:0]              swing_state;
	logic                    stance_state;

	// model copy of the leg state and registers
	lss_state_t  leg;
	lss_cfg_t    leg_cfg;
	lss_result_t pending_results[$];
	lss_result_t last_res;

	int send_gap_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int ticks_sent = 0;
	int reg_writes = 0;
	int swing_hits[4];
	int touch_hits = 0;
	int near_hits = 0;

	// simulated posture used to build well-formed walking sequences
	int pos_c, pos_f, pos_t;

	leg_swing_stance_selector uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.coxa_angle(coxa_angle),
		.femur_angle(femur_angle),
		.tibia_angle(tibia_angle),
		.contact_bits(contact_bits),
		.rule_inhibit(rule_inhibit),
		.rule_excite_two(rule_excite_two),
		.rule_excite_three(rule_excite_three),
		.clear_touch_down(clear_touch_down),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.via_coxa(via_coxa),
		.via_femur(via_femur),
		.via_tibia(via_tibia),
		.via_write_mask(via_write_mask),
		.position_mode(position_mode),
		.swing_phase(swing_phase),
		.foot_down(foot_down),
		.near_pep_toggle(near_pep_toggle),
		.swing_state(swing_state),
		.stance_state(stance_state)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp16(input int v);
		if (v > 32767) begin
			return 32767;
		end
		if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	function automatic bit in_band(input int tgt, input int ang, input int band);
		int d;
		d = tgt - ang;
		if (d < 0) begin
			d = -d;
		end
		return d < band;
	endfunction

	function automatic bit posture_at_pep(input int c, input int f, input int t, input int band);
		return in_band($signed(leg_cfg.pep_coxa), c, band)
			&& in_band($signed(leg_cfg.pep_femur), f, band)
			&& in_band($signed(leg_cfg.pep_tibia), t, band);
	endfunction

	// one control tick of the leg: updates leg state, returns the expected outputs
	task automatic step_leg(input lss_item_t it, output lss_result_t res);
		int c, f, t, trig_sum, rs, ps;
		int vc, vf, vt;
		bit gc, trig, posmode;
		logic [2:0] mask;
		c = $signed(it.coxa);
		f = $signed(it.femur);
		t = $signed(it.tibia);
		gc = |it.contact;
		vc = 0;
		vf = 0;
		vt = 0;
		mask = '0;
		posmode = 1'b0;

		if (it.clear_touch) begin
			leg.touch = 1'b0;
		end

		trig_sum = (in_band($signed(leg_cfg.pep_coxa), c, COARSE) ? 1 : 0)
			- int'(it.inhibit) + int'(it.excite_two) + int'(it.excite_three);
		trig = trig_sum > 0;

		if (trig && gc) begin
			vf = clamp16(f + LIFT_OFS);
			vt = clamp16(t - LIFT_OFS);
			mask |= MASK_FT;
		end

		rs = int'(leg.return_to_swing) + int'(trig) - int'(gc);
		ps = int'(leg.power_stroke) - int'(trig) + int'(gc);
		leg.return_to_swing = rs > 0;
		leg.power_stroke = ps > 0;

		if (leg.power_stroke && leg.pre_touch) begin
			leg.pre_touch = 1'b0;
			leg.start_swing = 1'b0;
			leg.touch = 1'b1;
		end

		if (leg.return_to_swing) begin
			leg.start_swing = 1'b1;
			leg.start_stance = 1'b0;
			leg.phase = 1'b1;
			posmode = 1'b1;
			case (leg.swing_fsm)
				SW_LIFT: begin
					if (!in_band($signed(leg_cfg.mid_femur), f, COARSE)
						&& !in_band($signed(leg_cfg.mid_tibia), t, COARSE)) begin
						vc = $signed(leg_cfg.pep_coxa);
						vf = $signed(leg_cfg.mid_femur);
						vt = $signed(leg_cfg.mid_tibia);
						mask |= MASK_ALL;
					end else begin
						leg.swing_fsm = SW_TO_AEP;
					end
				end
				SW_TO_AEP: begin
					if (!in_band($signed(leg_cfg.aep_coxa), c, COARSE)) begin
						vc = $signed(leg_cfg.aep_coxa);
						vf = $signed(leg_cfg.mid_femur);
						vt = $signed(leg_cfg.mid_tibia);
						mask |= MASK_ALL;
					end else begin
						leg.swing_fsm = SW_LOWER;
					end
				end
				SW_LOWER: begin
					if (!gc) begin
						vf = clamp16(f - LOWER_OFS);
						mask |= MASK_FEMUR;
						leg.pre_touch = 1'b1;
					end else begin
						// foot found the ground while lowering
						leg.touch = 1'b1;
						leg.start_swing = 1'b0;
						leg.swing_fsm = SW_IDLE;
					end
				end
				default: begin
					if (leg.start_swing) begin
						leg.swing_fsm = SW_LIFT;
					end
				end
			endcase
		end else if (trig && gc) begin
			vf = clamp16(f + NUDGE_FEMUR);
			vt = clamp16(t - NUDGE_TIBIA);
			mask |= MASK_FT;
		end else if (leg.power_stroke) begin
			leg.start_swing = 1'b0;
			leg.start_stance = 1'b1;
			leg.phase = 1'b0;
			posmode = 1'b1;
			if (leg.stance_fsm == ST_TO_PEP) begin
				if (!posture_at_pep(c, f, t, COARSE)) begin
					vc = $signed(leg_cfg.pep_coxa);
					vf = $signed(leg_cfg.pep_femur);
					vt = $signed(leg_cfg.pep_tibia);
					mask |= MASK_ALL;
				end else begin
					leg.start_stance = 1'b0;
					leg.stance_fsm = ST_IDLE;
				end
			end else if (leg.start_stance) begin
				leg.stance_fsm = ST_TO_PEP;
			end
			// toggles while the posture sits inside the fine band
			leg.near_pep = posture_at_pep(c, f, t, FINE) && !leg.near_pep;
		end

		res.via_coxa = vc[ANG_W-1:0];
		res.via_femur = vf[ANG_W-1:0];
		res.via_tibia = vt[ANG_W-1:0];
		res.mask = mask;
		res.position_mode = posmode;
		res.swing_phase = leg.phase;
		res.foot_down = leg.touch;
		res.near_pep_toggle = leg.near_pep;
		res.swing_state = leg.swing_fsm;
		res.stance_state = leg.stance_fsm;
	endtask

	// sends one tick, then records its expected outputs once the transfer happens
	task automatic send_tick(input lss_item_t it);
		lss_result_t res;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		coxa_angle <= it.coxa;
		femur_angle <= it.femur;
		tibia_angle <= it.tibia;
		contact_bits <= it.contact;
		rule_inhibit <= it.inhibit;
		rule_excite_two <= it.excite_two;
		rule_excite_three <= it.excite_three;
		clear_touch_down <= it.clear_touch;
		do @(posedge clk); while (in_stall);
		step_leg(it, res);
		pending_results.push_back(res);
		last_res = res;
		ticks_sent++;
		swing_hits[res.swing_state]++;
		if (res.foot_down) begin
			touch_hits++;
		end
		if (res.near_pep_toggle) begin
			near_hits++;
		end
	endtask

	// stop sending and let every outstanding result come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_results.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic signed [ANG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PEP_COXA:  leg_cfg.pep_coxa = val;
			REG_PEP_FEMUR: leg_cfg.pep_femur = val;
			REG_PEP_TIBIA: leg_cfg.pep_tibia = val;
			REG_MID_FEMUR: leg_cfg.mid_femur = val;
			REG_MID_TIBIA: leg_cfg.mid_tibia = val;
			REG_AEP_COXA:  leg_cfg.aep_coxa = val;
			default: ;
		endcase
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config(input lss_cfg_t c);
		drain();
		write_reg(REG_PEP_COXA, c.pep_coxa);
		write_reg(REG_PEP_FEMUR, c.pep_femur);
		write_reg(REG_PEP_TIBIA, c.pep_tibia);
		write_reg(REG_MID_FEMUR, c.mid_femur);
		write_reg(REG_MID_TIBIA, c.mid_tibia);
		write_reg(REG_AEP_COXA, c.aep_coxa);
	endtask

	function automatic lss_item_t tick(input int c, input int f, input int t, input int contact,
		input bit inh, input bit ex2, input bit ex3, input bit clr);
		lss_item_t it;
		it.coxa = c[ANG_W-1:0];
		it.femur = f[ANG_W-1:0];
		it.tibia = t[ANG_W-1:0];
		it.contact = contact[5:0];
		it.inhibit = inh;
		it.excite_two = ex2;
		it.excite_three = ex3;
		it.clear_touch = clr;
		return it;
	endfunction

	function automatic int move_joint(input int cur, input int tgt);
		int d, stride;
		d = tgt - cur;
		stride = $urandom_range(900, 40);
		if (d <= stride && d >= -stride) begin
			return clamp16(tgt + $urandom_range(24) - 12);
		end
		return clamp16(d > 0 ? cur + stride : cur - stride);
	endfunction

	function automatic int drift_joint(input int cur);
		return clamp16(cur + $urandom_range(60) - 30);
	endfunction

	// next tick of a plausible walk: joints chase the last commanded targets,
	// contact follows the phase; a share of ticks is pure noise
	task automatic next_walk_tick(output lss_item_t it);
		bit grounded;
		if ($urandom_range(99) < 12) begin
			it = tick($urandom(), $urandom(), $urandom(), $urandom_range(63),
				1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
			return;
		end
		pos_c = last_res.mask[0] ? move_joint(pos_c, $signed(last_res.via_coxa))
			: drift_joint(pos_c);
		pos_f = last_res.mask[1] ? move_joint(pos_f, $signed(last_res.via_femur))
			: drift_joint(pos_f);
		pos_t = last_res.mask[2] ? move_joint(pos_t, $signed(last_res.via_tibia))
			: drift_joint(pos_t);
		if (last_res.swing_phase) begin
			grounded = (last_res.swing_state == SW_LOWER) ? ($urandom_range(99) < 35)
				: ($urandom_range(99) < 4);
		end else if (in_band($signed(leg_cfg.pep_coxa), pos_c, COARSE)) begin
			grounded = $urandom_range(99) < 40;
		end else begin
			grounded = $urandom_range(99) < 95;
		end
		it = tick(pos_c, pos_f, pos_t, grounded ? $urandom_range(63, 1) : 0,
			$urandom_range(99) < 8, $urandom_range(99) < 8, $urandom_range(99) < 8,
			$urandom_range(99) < 10);
	endtask

	task automatic run_walk(input int count);
		lss_item_t it;
		pos_c = $signed(leg_cfg.aep_coxa);
		pos_f = $signed(leg_cfg.pep_femur);
		pos_t = $signed(leg_cfg.pep_tibia);
		repeat (count) begin
			next_walk_tick(it);
			send_tick(it);
		end
	endtask

	function automatic lss_cfg_t default_cfg();
		lss_cfg_t c;
		c.pep_coxa = PEP_COXA_RST;
		c.pep_femur = PEP_FEMUR_RST;
		c.pep_tibia = PEP_TIBIA_RST;
		c.mid_femur = MID_FEMUR_RST;
		c.mid_tibia = MID_TIBIA_RST;
		c.aep_coxa = AEP_COXA_RST;
		return c;
	endfunction

	// one full cycle by hand at the reset positions, with the corner cases along the way
	task automatic test_directed_cycle();
		send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0));
		send_tick(tick(32767, 32767, -32768, 63, 0, 1, 0, 0));
		send_tick(tick(-32768, -32768, 32767, 1, 0, 0, 1, 0));
		send_tick(tick(0, 0, 0, 63, 0, 0, 0, 0));
		send_tick(tick(0, 0, 0, 63, 0, 0, 0, 0));
		// all three rules at once, sum clamps
		send_tick(tick(3277, 7373, -4506, 1, 1, 1, 1, 0));
		send_tick(tick(3277, 7373, -4506, 1, 0, 0, 0, 0));
		// lift-off, then lift, swing forward, lower
		send_tick(tick(3277, 7373, -4506, 0, 0, 0, 0, 0));
		send_tick(tick(3277, 7373, -4506, 0, 0, 0, 0, 0));
		send_tick(tick(3277, 8192, -4506, 0, 0, 0, 0, 0));
		send_tick(tick(0, 8192, -8192, 0, 0, 0, 0, 0));
		send_tick(tick(-7373, 8192, -8192, 0, 0, 0, 0, 0));
		send_tick(tick(-7373, 8192, -8192, 0, 0, 0, 0, 0));
		send_tick(tick(-7373, -32768, -8192, 0, 0, 0, 0, 0));
		send_tick(tick(-7373, 0, 0, 32, 0, 1, 0, 0));
		send_tick(tick(-7373, 0, 0, 2, 0, 0, 0, 1));
		send_tick(tick(-7373, 0, 0, 2, 0, 0, 0, 1));
		// stance held on the extreme position by inhibit: near flag alternates
		send_tick(tick(3277, 7373, -4506, 4, 1, 0, 0, 0));
		send_tick(tick(3277, 7373, -4506, 4, 1, 0, 0, 0));
		send_tick(tick(3277, 7373, -4506, 4, 1, 0, 0, 0));
		send_tick(tick(3277, 7373, -4506, 8, 1, 0, 0, 0));
		send_tick(tick(3277, 7373, -4506, 16, 1, 0, 0, 0));
		drain();
	endtask

	task automatic test_default_walk();
		send_gap_pct = 0;
		stall_pct = 0;
		run_walk(250);
	endtask

	task automatic test_random_config();
		lss_cfg_t c;
		c = lss_cfg_t'({$urandom(), $urandom(), $urandom()});
		load_config(c);
		send_gap_pct = 62;
		stall_pct = 0;
		run_walk(200);
	endtask

	task automatic test_max_config();
		load_config({6{16'sh7fff}});
		send_gap_pct = 0;
		stall_pct = 62;
		run_walk(150);
	endtask

	task automatic test_min_config();
		load_config({6{16'sh8000}});
		send_gap_pct = 31;
		stall_pct = 31;
		run_walk(150);
	endtask

	task automatic test_default_restored();
		load_config(default_cfg());
		send_gap_pct = 31;
		stall_pct = 31;
		run_walk(150);
		drain();
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches = mismatches + 1;
		end
	endfunction

	always @(posedge clk) begin : result_check
		lss_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no tick outstanding");
				mismatches = mismatches + 1;
			end else begin
				want = pending_results.pop_front();
				check_field("via_coxa", $signed(want.via_coxa), $signed(via_coxa));
				check_field("via_femur", $signed(want.via_femur), $signed(via_femur));
				check_field("via_tibia", $signed(want.via_tibia), $signed(via_tibia));
				check_field("via_write_mask", want.mask, via_write_mask);
				check_field("position_mode", want.position_mode, position_mode);
				check_field("swing_phase", want.swing_phase, swing_phase);
				check_field("foot_down", want.foot_down, foot_down);
				check_field("near_pep_toggle", want.near_pep_toggle, near_pep_toggle);
				check_field("swing_state", want.swing_state, swing_state);
				check_field("stance_state", want.stance_state, stance_state);
			end
		end
	end

	// counts cycles without any transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("timeout after %0d quiet cycles", QUIET_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		leg = '0;
		leg_cfg = default_cfg();
		last_res = '0;
		foreach (swing_hits[i]) begin
			swing_hits[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cycle();
		test_default_walk();
		test_random_config();
		test_max_config();
		test_min_config();
		test_default_restored();

		$display("checked %0d ticks across %0d register writes and five register settings",
			ticks_sent, reg_writes);
		$display("states seen: idle %0d, lift %0d, to-aep %0d, lower %0d; touch %0d, near-pep %0d",
			swing_hits[0], swing_hits[1], swing_hits[2], swing_hits[3], touch_hits, near_hits);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> leg_swing_stance_selector.f
rtl/lss_pkg.sv
rtl/lss_cfg.sv
rtl/lss_step.sv
rtl/leg_swing_stance_selector.sv
test/tb.sv
